// ===== hw/rtl/vsc_pkg.sv =====
package vsc_pkg;

    localparam int SLOTS = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int TAG_W = 42;
    localparam int ELEM_W = 24;
    localparam int BYTES_W = 27;
    localparam int POS_W = 12;
    localparam int CH_W = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;
    localparam int DIV_STEPS = POS_W;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLAB_ROWS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 3'd4;

    typedef struct packed {
        logic load;
        logic div_step;
        logic mul1;
        logic mul2;
        logic mul3;
        logic scan_step;
        logic update;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic match;
        logic scan_last;
        logic out_free;
    } status_t;

    function automatic logic [CNT_W-1:0] eff_slots(input logic [4:0] s);
        logic [CNT_W-1:0] r;
        if (s == 5'd0)
        begin
            r = CNT_W'(1);
        end
        else if (32'(s) > SLOTS)
        begin
            r = CNT_W'(SLOTS);
        end
        else
        begin
            r = CNT_W'(s);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/vsc_if.sv =====
interface vsc_req_if;
    logic valid;
    logic ready;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [11:0] pos_z;
    logic [3:0] channel;

    modport source (output valid, pos_x, pos_y, pos_z, channel, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, channel, output ready);
endinterface

interface vsc_rsp_if;
    logic valid;
    logic ready;
    logic hit;
    logic [3:0] slot;
    logic [23:0] element_offset;
    logic fill_needed;
    logic [41:0] fill_address;
    logic [26:0] fill_bytes;

    modport source (output valid, hit, slot, element_offset, fill_needed, fill_address,
        fill_bytes, input ready);
    modport sink (input valid, hit, slot, element_offset, fill_needed, fill_address,
        fill_bytes, output ready);
endinterface

interface vsc_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] index;
    logic [12:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/vsc_datapath.sv =====
module vsc_datapath (
    input  logic clk,
    input  logic rst_n,
    input  vsc_pkg::cmd_t cmd,
    output vsc_pkg::status_t status,
    input  logic cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [12:0] cfg_data,
    input  logic [11:0] pos_x,
    input  logic [11:0] pos_y,
    input  logic [11:0] pos_z,
    input  logic [3:0] channel,
    output logic out_valid,
    input  logic out_ready,
    output logic hit,
    output logic [3:0] slot,
    output logic [23:0] element_offset,
    output logic fill_needed,
    output logic [41:0] fill_address,
    output logic [26:0] fill_bytes
);
    import vsc_pkg::*;

    logic [12:0] size_x_reg, size_y_reg;
    logic [8:0] slab_rows_reg;
    logic [4:0] channels_reg, slots_reg;

    logic [11:0] x_reg, y_reg, z_reg, yq_reg;
    logic [3:0] ch_reg;
    logic [8:0] rem_reg;
    logic [3:0] cnt_reg;
    logic [11:0] start_reg;
    logic [24:0] zs_reg;
    logic [17:0] rb_reg;
    logic [21:0] oy_reg;
    logic [25:0] base_reg;
    logic [19:0] rowb_reg;
    logic [27:0] ea_reg;
    logic [12:0] len_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [ELEM_W-1:0] elem_reg;
    logic [BYTES_W-1:0] bytes_reg;

    logic [TAG_W-1:0] tag_mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    logic [TAG_W-1:0] rd_reg;
    logic [SLOT_W-1:0] idx_reg, rd_addr;
    logic [SLOT_W-1:0] victim_reg;
    logic hit_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic out_valid_reg;
    logic out_hit_reg;
    logic [3:0] out_slot_reg;
    logic [ELEM_W-1:0] out_elem_reg;
    logic [TAG_W-1:0] out_addr_reg;
    logic [BYTES_W-1:0] out_bytes_reg;

    logic [8:0] rows;
    logic [9:0] rem_shift;
    logic [8:0] rem_next;
    logic [11:0] start_next;
    logic [12:0] slab_end;
    logic [CNT_W-1:0] n_cur, n_new;
    logic [SLOT_W-1:0] last_idx, victim_eff;
    logic [4:0] slots_new;
    logic [TAG_W-1:0] tag_prod;
    logic [BYTES_W-1:0] bytes_prod;
    logic [22:0] xo_sum;

    assign rows = (slab_rows_reg == 9'd0) ? 9'd1 : slab_rows_reg;
    assign rem_shift = {rem_reg, yq_reg[11]};
    assign rem_next = (rem_shift >= {1'b0, rows}) ? 9'(rem_shift - {1'b0, rows})
                    : rem_shift[8:0];
    assign start_next = y_reg - {3'b000, rem_reg};
    assign slab_end = {1'b0, start_reg} + {4'b0000, rows};
    assign n_cur = eff_slots(slots_reg);
    assign last_idx = SLOT_W'(n_cur - CNT_W'(1));
    assign victim_eff = (victim_reg > last_idx) ? last_idx : victim_reg;
    assign slots_new = (cfg_index == REG_SLOTS_IN_USE) ? cfg_data[4:0] : slots_reg;
    assign n_new = eff_slots(slots_new);
    assign tag_prod = TAG_W'(46'(base_reg) * 46'(rowb_reg));
    assign bytes_prod = BYTES_W'(33'(len_reg) * 33'(rowb_reg));
    assign xo_sum = 23'(x_reg) + 23'(oy_reg);
    assign rd_addr = cmd.mul3 ? '0 : idx_reg + SLOT_W'(1);

    assign status.div_last = (cnt_reg == 4'(DIV_STEPS - 1));
    assign status.match = valid_reg[idx_reg] && (rd_reg == tag_reg);
    assign status.scan_last = (idx_reg == last_idx);
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= 13'd1;
            size_y_reg <= 13'd1;
            slab_rows_reg <= 9'd1;
            channels_reg <= 5'd1;
            slots_reg <= 5'd16;
            valid_reg <= '0;
            victim_reg <= SLOT_W'(SLOTS - 1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && cfg_index <= REG_SLOTS_IN_USE)
            begin
                case (cfg_index)
                    REG_SIZE_X: size_x_reg <= cfg_data;
                    REG_SIZE_Y: size_y_reg <= cfg_data;
                    REG_SLAB_ROWS: slab_rows_reg <= cfg_data[8:0];
                    REG_CHANNELS: channels_reg <= cfg_data[4:0];
                    REG_SLOTS_IN_USE: slots_reg <= cfg_data[4:0];
                    default: slots_reg <= slots_reg;
                endcase
                valid_reg <= '0;
                victim_reg <= SLOT_W'(n_new - CNT_W'(1));
            end
            else if (cmd.update)
            begin
                valid_reg[slot_reg] <= 1'b1;
                victim_reg <= (slot_reg == '0) ? last_idx : slot_reg - SLOT_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= tag_mem[rd_addr];
        if (cmd.update)
        begin
            tag_mem[slot_reg] <= tag_reg;
        end
        if (cmd.load)
        begin
            x_reg <= pos_x;
            y_reg <= pos_y;
            yq_reg <= pos_y;
            z_reg <= pos_z;
            ch_reg <= channel;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            yq_reg <= {yq_reg[10:0], 1'b0};
            cnt_reg <= cnt_reg + 4'd1;
        end
        if (cmd.mul1)
        begin
            start_reg <= start_next;
            zs_reg <= 25'(z_reg) * 25'(size_y_reg);
            rb_reg <= 18'(size_x_reg) * 18'(channels_reg);
            oy_reg <= 22'(rem_reg) * 22'(size_x_reg);
        end
        if (cmd.mul2)
        begin
            base_reg <= 26'(zs_reg) + 26'(start_reg);
            rowb_reg <= {rb_reg, 2'b00};
            ea_reg <= 28'(xo_sum) * 28'(channels_reg);
            if (slab_end > size_y_reg)
            begin
                len_reg <= ({1'b0, start_reg} >= size_y_reg) ? 13'd0
                         : size_y_reg - {1'b0, start_reg};
            end
            else
            begin
                len_reg <= {4'b0000, rows};
            end
        end
        if (cmd.mul3)
        begin
            tag_reg <= tag_prod;
            elem_reg <= ELEM_W'(ea_reg + 28'(ch_reg));
            bytes_reg <= bytes_prod;
            idx_reg <= '0;
        end
        if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + SLOT_W'(1);
            if (status.match)
            begin
                hit_reg <= 1'b1;
                slot_reg <= idx_reg;
            end
            else
            begin
                hit_reg <= 1'b0;
                slot_reg <= victim_eff;
            end
        end
        if (cmd.out_load)
        begin
            out_hit_reg <= hit_reg;
            out_slot_reg <= 4'(slot_reg);
            out_elem_reg <= elem_reg;
            out_addr_reg <= hit_reg ? '0 : tag_reg;
            out_bytes_reg <= hit_reg ? '0 : bytes_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit = out_hit_reg;
    assign slot = out_slot_reg;
    assign element_offset = out_elem_reg;
    assign fill_needed = !out_hit_reg;
    assign fill_address = out_addr_reg;
    assign fill_bytes = out_bytes_reg;

endmodule

// ===== hw/rtl/vsc_ctrl.sv =====
module vsc_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  vsc_pkg::status_t status,
    output vsc_pkg::cmd_t cmd
);
    import vsc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_MUL3 = 3'd4;
    localparam logic [2:0] S_SCAN = 3'd5;
    localparam logic [2:0] S_UPD = 3'd6;
    localparam logic [2:0] S_OUT = 3'd7;

    logic [2:0] state_reg, state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul1 = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2 = 1'b1;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.mul3 = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.match)
                begin
                    state_next = S_OUT;
                end
                else if (status.scan_last)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/volume_slice_cache_fifo.sv =====
// channel  dir  handshake     payload
// req      in   valid/ready   pos_x, pos_y, pos_z, channel
// rsp      out  valid/ready   hit, slot, element_offset, fill_needed, fill_address, fill_bytes
// cfg      in   valid/ready   index, data (ready held high)
// One item at a time: a bit-serial remainder by slab_rows, the multiply states MUL1,
// MUL2 and MUL3, then a tag scan of one slot per cycle.
// Reset clears all valid marks; a write to a defined register (index 0 to 4) flushes them again.
// The result register lets the next item start while rsp is stalled.
module volume_slice_cache_fifo (
    input logic clk,
    input logic rst_n,
    vsc_req_if.sink req,
    vsc_rsp_if.source rsp,
    vsc_cfg_if.sink cfg
);
    import vsc_pkg::*;

    cmd_t cmd;
    status_t status;

    assign cfg.ready = 1'b1;

    vsc_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req.valid),
        .req_ready(req.ready),
        .status(status),
        .cmd(cmd)
    );

    vsc_datapath u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .status(status),
        .cfg_write(cfg.valid),
        .cfg_index(cfg.index),
        .cfg_data(cfg.data),
        .pos_x(req.pos_x),
        .pos_y(req.pos_y),
        .pos_z(req.pos_z),
        .channel(req.channel),
        .out_valid(rsp.valid),
        .out_ready(rsp.ready),
        .hit(rsp.hit),
        .slot(rsp.slot),
        .element_offset(rsp.element_offset),
        .fill_needed(rsp.fill_needed),
        .fill_address(rsp.fill_address),
        .fill_bytes(rsp.fill_bytes)
    );

endmodule

// ===== test/vsc_checker.sv =====
module vsc_checker (
    input logic clk,
    input logic rst_n,
    vsc_req_if req,
    vsc_rsp_if rsp,
    vsc_cfg_if cfg,
    output int fails,
    output int pending
);
    import vsc_pkg::*;

    typedef struct packed {
        logic hit;
        logic [3:0] slot;
        logic [23:0] element_offset;
        logic fill_needed;
        logic [41:0] fill_address;
        logic [26:0] fill_bytes;
    } slab_lookup_t;

    slab_lookup_t lookup_q[$];

    logic [12:0] size_x;
    logic [12:0] size_y;
    logic [8:0] slab_rows;
    logic [4:0] channels;
    logic [4:0] slots_in_use;
    logic [41:0] tag_mem[SLOTS];
    logic resident[SLOTS];
    int victim;

    function automatic int slot_count();
        int s;
        s = slots_in_use;
        if (s == 0)
        begin
            s = 1;
        end
        if (s > SLOTS)
        begin
            s = SLOTS;
        end
        return s;
    endfunction

    task automatic flush_slabs();
        for (int i = 0; i < SLOTS; i++)
        begin
            resident[i] = 1'b0;
        end
        victim = slot_count() - 1;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
        case (idx)
            REG_SIZE_X: size_x = val;
            REG_SIZE_Y: size_y = val;
            REG_SLAB_ROWS: slab_rows = val[8:0];
            REG_CHANNELS: channels = val[4:0];
            REG_SLOTS_IN_USE: slots_in_use = val[4:0];
            default: return;
        endcase
        flush_slabs();
    endtask

    task automatic look_up(input logic [11:0] px, input logic [11:0] py,
        input logic [11:0] pz, input logic [3:0] pch, output slab_lookup_t r);
        logic [63:0] rows;
        logic [63:0] off_y;
        logic [63:0] start;
        logic [63:0] row_bytes;
        logic [63:0] tag;
        logic [63:0] elem;
        logic [63:0] nbytes;
        int n;
        int found;
        logic hit;
        rows = (slab_rows == 0) ? 64'd1 : 64'(slab_rows);
        off_y = 64'(py) % rows;
        start = 64'(py) - off_y;
        row_bytes = 64'(size_x) * 64'(channels) * 64'd4;
        tag = ((start + 64'(pz) * 64'(size_y)) * row_bytes) & 64'h3FF_FFFF_FFFF;
        elem = (64'(px) + off_y * 64'(size_x)) * 64'(channels) + 64'(pch);
        n = slot_count();
        hit = 1'b0;
        found = 0;
        for (int i = 0; i < n; i++)
        begin
            if (!hit && resident[i] && tag_mem[i] == tag[41:0])
            begin
                hit = 1'b1;
                found = i;
            end
        end
        r = '0;
        r.hit = hit;
        r.element_offset = elem[23:0];
        if (!hit)
        begin
            if (victim >= n)
            begin
                victim = n - 1;
            end
            found = victim;
            victim = (victim == 0) ? n - 1 : victim - 1;
            tag_mem[found] = tag[41:0];
            resident[found] = 1'b1;
            if (start + rows > 64'(size_y))
            begin
                nbytes = (start >= 64'(size_y)) ? 64'd0 : (64'(size_y) - start) * row_bytes;
            end
            else
            begin
                nbytes = rows * row_bytes;
            end
            r.fill_needed = 1'b1;
            r.fill_address = tag[41:0];
            r.fill_bytes = nbytes[26:0];
        end
        r.slot = found[3:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        slab_lookup_t want;
        slab_lookup_t got;
        if (!rst_n)
        begin
            size_x = 13'd1;
            size_y = 13'd1;
            slab_rows = 9'd1;
            channels = 5'd1;
            slots_in_use = 5'd16;
            flush_slabs();
            lookup_q.delete();
            fails = 0;
            pending = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                write_reg(cfg.index, cfg.data);
            end
            if (rsp.valid && rsp.ready)
            begin
                got.hit = rsp.hit;
                got.slot = rsp.slot;
                got.element_offset = rsp.element_offset;
                got.fill_needed = rsp.fill_needed;
                got.fill_address = rsp.fill_address;
                got.fill_bytes = rsp.fill_bytes;
                if (lookup_q.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                    begin
                        $display("unexpected item: %p", got);
                    end
                end
                else
                begin
                    want = lookup_q.pop_front();
                    if (got !== want)
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $display("mismatch: expected %p", want);
                            $display("          actual   %p", got);
                        end
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                look_up(req.pos_x, req.pos_y, req.pos_z, req.channel, want);
                lookup_q.insert(lookup_q.size(), want);
            end
            pending = lookup_q.size();
        end
    end

endmodule

// ===== test/volume_slice_cache_fifo_test.sv =====
module volume_slice_cache_fifo_test;
    import vsc_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASES = 8;
    localparam int RANDOM_PER_PHASE = 165;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int fails;
    int pending;
    int cycles = 0;
    int sent = 0;
    logic calm = 1'b0;

    int ph_sx[PHASES] = '{64, 4096, 1, 37, 200, 8191, 13, 1000};
    int ph_sy[PHASES] = '{100, 4096, 1, 50, 333, 8191, 9, 2047};
    int ph_rows[PHASES] = '{8, 256, 1, 0, 7, 511, 16, 3};
    int ph_ch[PHASES] = '{3, 16, 1, 2, 5, 31, 1, 4};
    int ph_slots[PHASES] = '{4, 16, 1, 0, 20, 31, 3, 16};

    vsc_req_if req ();
    vsc_rsp_if rsp ();
    vsc_cfg_if cfg ();

    volume_slice_cache_fifo DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp),
        .cfg(cfg)
    );

    vsc_checker slab_check (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp),
        .cfg(cfg),
        .fails(fails),
        .pending(pending)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rsp.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            rsp.ready <= 1'b1;
        end
    end

    task automatic send_voxel(input logic [11:0] x, input logic [11:0] y,
        input logic [11:0] z, input logic [3:0] ch);
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.pos_x <= x;
        req.pos_y <= y;
        req.pos_z <= z;
        req.channel <= ch;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        sent++;
        if (sent > 1200)
        begin
            calm = 1'b1;
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input int val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val[12:0];
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_voxel(input int p);
        int rows;
        int slabs;
        int y;
        rows = (ph_rows[p] % 512 == 0) ? 1 : ph_rows[p] % 512;
        slabs = (ph_sy[p] % 4096) / rows + 2;
        if (slabs > 12)
        begin
            slabs = 12;
        end
        if ($urandom_range(0, 9) < 7)
        begin
            y = $urandom_range(0, slabs - 1) * rows + $urandom_range(0, rows - 1);
            send_voxel(12'($urandom_range(0, (ph_sx[p] > 4096 ? 4096 : ph_sx[p]) - 1)),
                y[11:0], 12'($urandom_range(0, 2)), 4'($urandom_range(0, 15)));
        end
        else
        begin
            send_voxel(12'($urandom), 12'($urandom), 12'($urandom), 4'($urandom));
        end
    endtask

    initial
    begin
        req.valid <= 1'b0;
        req.pos_x <= '0;
        req.pos_y <= '0;
        req.pos_z <= '0;
        req.channel <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= '0;
        cfg.data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_voxel(12'd0, 12'd0, 12'd0, 4'd0);
        send_voxel(12'd0, 12'd0, 12'd0, 4'd15);
        send_voxel(12'd4095, 12'd4095, 12'd4095, 4'd15);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            write_cfg(REG_SIZE_X, ph_sx[p]);
            write_cfg(REG_SIZE_Y, ph_sy[p]);
            write_cfg(REG_SLAB_ROWS, ph_rows[p]);
            write_cfg(REG_CHANNELS, ph_ch[p]);
            write_cfg(REG_SLOTS_IN_USE, ph_slots[p]);
            if (p == 0)
            begin
                write_cfg(3'd7, 13'h1FFF);
                send_voxel(12'd0, 12'd0, 12'd0, 4'd0);
                send_voxel(12'd63, 12'd7, 12'd0, 4'd15);
                send_voxel(12'd5, 12'd8, 12'd0, 4'd1);
                send_voxel(12'd5, 12'd99, 12'd0, 4'd2);
                send_voxel(12'd5, 12'd200, 12'd0, 4'd2);
                send_voxel(12'd1, 12'd3, 12'd1, 4'd0);
                send_voxel(12'd1, 12'd3, 12'd2, 4'd0);
                send_voxel(12'd2, 12'd1, 12'd0, 4'd3);
                send_voxel(12'd2, 12'd9, 12'd0, 4'd3);
                send_voxel(12'd4095, 12'd4095, 12'd4095, 4'd15);
                send_voxel(12'd4095, 12'd4095, 12'd4095, 4'd0);
                send_voxel(12'd0, 12'd96, 12'd0, 4'd0);
                send_voxel(12'd0, 12'd0, 12'd0, 4'd0);
                send_voxel(12'd0, 12'd0, 12'd4095, 4'd7);
                send_voxel(12'hAAA, 12'h555, 12'hAAA, 4'h5);
                send_voxel(12'h555, 12'hAAA, 12'h555, 4'hA);
            end
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                if (p == 3 && i == RANDOM_PER_PHASE / 2)
                begin
                    req.valid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0) @(posedge clk);
                end
                random_voxel(p);
            end
            drain();
        end

        repeat (100) @(posedge clk);
        if (fails == 0 && pending == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/vsc_pkg.sv
hw/rtl/vsc_if.sv
hw/rtl/vsc_datapath.sv
hw/rtl/vsc_ctrl.sv
hw/rtl/volume_slice_cache_fifo.sv
test/vsc_checker.sv
test/volume_slice_cache_fifo_test.sv
